FILE: rtl/pmet_pkg.sv
// Shared types, constants and helpers for the process memory event tracker.
package pmet_pkg;

   // Table size default for the top-level parameter.
   localparam int TABLE_ENTRIES_DEFAULT = 128;

   // Field widths fixed by the event format.
   localparam int PID_W    = 22;
   localparam int CALL_W   = 10;
   localparam int WORD_W   = 32;
   localparam int COUNT_W  = 16;
   localparam int WINDOW_W = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MPROTECT_CALL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MMAP_CALL      = 2'd2;

   // Configuration reset values.
   localparam logic [WINDOW_W-1:0] WINDOW_SECONDS_RESET = 16'd30;
   localparam logic [CALL_W-1:0]   MPROTECT_CALL_RESET  = 10'd10;
   localparam logic [CALL_W-1:0]   MMAP_CALL_RESET      = 10'd9;

   // Score kinds reported with each transaction.
   localparam logic [1:0] SCORE_NONE       = 2'd0;
   localparam logic [1:0] SCORE_INJECTION  = 2'd1;
   localparam logic [1:0] SCORE_PROTECTION = 2'd2;
   localparam logic [1:0] SCORE_MAPPING    = 2'd3;

   // Event decoding constants.
   localparam logic [2:0]         PROT_RWX     = 3'b111;
   localparam int                 PROT_X_BIT   = 2;
   localparam int                 MAP_ANON_BIT = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
   localparam logic [COUNT_W-1:0] LOW_COUNT_LIMIT = 16'd3;

   // Reciprocal of ten: (x * 0xCCCD) >> 19 equals x / 10 for every 16-bit x.
   localparam logic [COUNT_W-1:0] DIV10_RECIP = 16'hCCCD;
   localparam int                 DIV10_SHIFT = 19;

   // Input transaction.
   typedef struct packed {
      logic [PID_W-1:0]  process_id;
      logic [CALL_W-1:0] call_number;
      logic [WORD_W-1:0] protection_bits;
      logic [WORD_W-1:0] mapping_flags;
      logic [WORD_W-1:0] now_seconds;
   } pmet_req_type;

   // Result transaction.
   typedef struct packed {
      logic               suspicious;
      logic               injection_detected;
      logic [1:0]         score_kind;
      logic               log_warning;
      logic [COUNT_W-1:0] flag_count;
   } pmet_rsp_type;

   // One table entry as stored in memory.
   typedef struct packed {
      logic [PID_W-1:0]   process_id;
      logic [WORD_W-1:0]  window_start;
      logic [COUNT_W-1:0] alert_count;
      logic               rwx_seen;
      logic               anon_exec_seen;
      logic               reported;
   } pmet_entry_type;

   // Outcome of applying one event, before the warning hint is worked out.
   typedef struct packed {
      logic               suspicious;
      logic               injection;
      logic               warn_candidate;
      logic [1:0]         score_kind;
      logic [COUNT_W-1:0] flag_count;
   } pmet_verdict_type;

   // A freshly opened window for a process.
   function automatic pmet_entry_type fresh_entry(input logic [PID_W-1:0]  pid,
                                                  input logic [WORD_W-1:0] now);
      pmet_entry_type e;
      e.process_id     = pid;
      e.window_start   = now;
      e.alert_count    = '0;
      e.rwx_seen       = 1'b0;
      e.anon_exec_seen = 1'b0;
      e.reported       = 1'b0;
      return e;
   endfunction

endpackage

FILE: rtl/pmet_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pmet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pmet_event.sv
// Applies one event to a table entry: window aging, flag updates and injection report.
module pmet_event
   import pmet_pkg::*;
(
   input  pmet_req_type        req,
   input  pmet_entry_type      entry,
   input  logic [WINDOW_W-1:0] window_seconds,
   input  logic [CALL_W-1:0]   mprotect_call,
   input  logic [CALL_W-1:0]   mmap_call,
   output pmet_entry_type      next_entry,
   output pmet_verdict_type    verdict
);

   logic [WORD_W-1:0] age;
   logic              stale;
   logic              is_mprotect;
   logic              is_mmap;
   logic              rwx_hit;
   logic              anon_hit;
   logic              susp;
   logic              inject;
   pmet_entry_type    base;
   pmet_entry_type    upd;

   // Age is taken modulo 2^32, so a time that runs backwards looks stale.
   assign age   = req.now_seconds - entry.window_start;
   assign stale = age > {{(WORD_W-WINDOW_W){1'b0}}, window_seconds};

   // Classify the call; a match on the protection call number takes priority.
   assign is_mprotect = req.call_number == mprotect_call;
   assign is_mmap     = !is_mprotect && (req.call_number == mmap_call);
   assign rwx_hit     = is_mprotect && (req.protection_bits[2:0] == PROT_RWX);
   assign anon_hit    = is_mmap && req.mapping_flags[MAP_ANON_BIT]
                        && req.protection_bits[PROT_X_BIT];
   assign susp        = rwx_hit || anon_hit;

   // Build the updated entry and decide on the one-time injection report.
   always_comb begin
      base = stale ? fresh_entry(req.process_id, req.now_seconds) : entry;
      upd  = base;
      if (rwx_hit) begin
         upd.rwx_seen = 1'b1;
      end
      if (anon_hit) begin
         upd.anon_exec_seen = 1'b1;
      end
      if (susp && (base.alert_count != COUNT_MAX)) begin
         upd.alert_count = base.alert_count + 1'b1;
      end
      inject = upd.rwx_seen && upd.anon_exec_seen && !upd.reported;
      if (inject) begin
         upd.reported = 1'b1;
      end
   end

   assign next_entry = upd;

   // Summary of the transaction; the warning hint only applies without a report.
   always_comb begin
      verdict.suspicious     = susp || inject;
      verdict.injection      = inject;
      verdict.warn_candidate = susp && !inject;
      verdict.flag_count     = upd.alert_count;
      if (inject) begin
         verdict.score_kind = SCORE_INJECTION;
      end else if (rwx_hit) begin
         verdict.score_kind = SCORE_PROTECTION;
      end else if (anon_hit) begin
         verdict.score_kind = SCORE_MAPPING;
      end else begin
         verdict.score_kind = SCORE_NONE;
      end
   end

endmodule

FILE: rtl/process_memory_event_tracker.sv
// A transaction scans the occupied entries for its process; without a match it appends
// a fresh entry, or in a full table evicts the entry with the oldest window start.
// Throughput: one transaction at a time, with one table read per cycle for lookup and
// oldest search; a result waits in the last state while the previous one is stalled.
// The next request is taken while a finished result still waits on the output.
// Reset (synchronous) empties the table, clears the output and restores the
// configuration defaults; the table memory itself is not swept.
module process_memory_event_tracker
   import pmet_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pmet_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pmet_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [OCC_W-1:0] ENTRIES_CNT = OCC_W'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_OLDEST,
      ST_APPLY,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   pmet_req_type        req_ff, req_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [OCC_W-1:0]    issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    tag_ff, tag_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   pmet_entry_type      entry_ff, entry_in;
   logic [WORD_W-1:0]   best_ws_ff, best_ws_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic                best_ok_ff, best_ok_in;
   pmet_verdict_type    verdict_ff, verdict_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pmet_rsp_type        rsp_ff, rsp_in;
   logic [WINDOW_W-1:0] window_ff;
   logic [CALL_W-1:0]   mprotect_ff;
   logic [CALL_W-1:0]   mmap_ff;

   logic                rd_en;
   logic                wr_en;
   logic [$bits(pmet_entry_type)-1:0] rd_raw;
   pmet_entry_type      rd_entry;
   pmet_entry_type      upd_entry;
   pmet_verdict_type    upd_verdict;
   logic [2*COUNT_W-1:0] div_prod;
   logic [2*COUNT_W-1-DIV10_SHIFT:0] div_quot;
   logic [COUNT_W-1:0]  quot_x10;
   logic                warn;

   // Entry table memory.
   pmet_ram #(
      .WIDTH ($bits(pmet_entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (upd_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry = rd_raw;

   // Event rules applied to the selected entry.
   pmet_event u_event (
      .req            (req_ff),
      .entry          (entry_ff),
      .window_seconds (window_ff),
      .mprotect_call  (mprotect_ff),
      .mmap_call      (mmap_ff),
      .next_entry     (upd_entry),
      .verdict        (upd_verdict)
   );

   // One read per cycle while scanning the occupied entries or the whole table.
   assign rd_en = ((state_ff == ST_LOOK) && (issue_ff < occ_ff))
                  || ((state_ff == ST_OLDEST) && (issue_ff < ENTRIES_CNT));
   assign wr_en = state_ff == ST_APPLY;

   // Warning hint: count at most three, or a multiple of ten via the reciprocal.
   assign div_prod = {{COUNT_W{1'b0}}, verdict_ff.flag_count}
                     * {{COUNT_W{1'b0}}, DIV10_RECIP};
   assign div_quot = div_prod[2*COUNT_W-1:DIV10_SHIFT];
   assign quot_x10 = COUNT_W'({div_quot, 3'b000}) + COUNT_W'({div_quot, 1'b0});
   assign warn     = verdict_ff.warn_candidate
                     && ((verdict_ff.flag_count <= LOW_COUNT_LIMIT)
                         || (quot_x10 == verdict_ff.flag_count));

   // Next-state logic for the lookup, eviction search and update sequence.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      occ_in       = occ_ff;
      issue_in     = issue_ff + OCC_W'(rd_en);
      pend_in      = rd_en;
      tag_in       = issue_ff[IDX_W-1:0];
      slot_in      = slot_ff;
      entry_in     = entry_ff;
      best_ws_in   = best_ws_ff;
      best_idx_in  = best_idx_ff;
      best_ok_in   = best_ok_ff;
      verdict_in   = verdict_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               issue_in = '0;
               pend_in  = 1'b0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (pend_ff && (rd_entry.process_id == req_ff.process_id)) begin
               slot_in  = tag_ff;
               entry_in = rd_entry;
               state_in = ST_APPLY;
            end else if (!pend_ff && (issue_ff >= occ_ff)) begin
               if (occ_ff < ENTRIES_CNT) begin
                  slot_in  = occ_ff[IDX_W-1:0];
                  occ_in   = occ_ff + 1'b1;
                  entry_in = fresh_entry(req_ff.process_id, req_ff.now_seconds);
                  state_in = ST_APPLY;
               end else begin
                  issue_in   = '0;
                  pend_in    = 1'b0;
                  best_ok_in = 1'b0;
                  state_in   = ST_OLDEST;
               end
            end
         end
         ST_OLDEST: begin
            // Strict compare keeps the lowest index on ties.
            if (pend_ff && (!best_ok_ff || (rd_entry.window_start < best_ws_ff))) begin
               best_ws_in  = rd_entry.window_start;
               best_idx_in = tag_ff;
               best_ok_in  = 1'b1;
            end
            if (!pend_ff && (issue_ff >= ENTRIES_CNT)) begin
               slot_in  = best_idx_ff;
               entry_in = fresh_entry(req_ff.process_id, req_ff.now_seconds);
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            verdict_in = upd_verdict;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.suspicious         = verdict_ff.suspicious;
               rsp_in.injection_detected = verdict_ff.injection;
               rsp_in.score_kind         = verdict_ff.score_kind;
               rsp_in.log_warning        = warn;
               rsp_in.flag_count         = verdict_ff.flag_count;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, datapath and output registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      tag_ff      <= tag_in;
      slot_ff     <= slot_in;
      entry_ff    <= entry_in;
      best_ws_ff  <= best_ws_in;
      best_idx_ff <= best_idx_in;
      verdict_ff  <= verdict_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         best_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         best_ok_ff   <= best_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WINDOW_SECONDS_RESET;
         mprotect_ff <= MPROTECT_CALL_RESET;
         mmap_ff     <= MMAP_CALL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SECONDS: window_ff   <= csr_wdata[WINDOW_W-1:0];
            CSR_MPROTECT_CALL:  mprotect_ff <= csr_wdata[CALL_W-1:0];
            CSR_MMAP_CALL:      mmap_ff     <= csr_wdata[CALL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/pmet_checker.sv
// Port-level assertions for the process memory event tracker, bound to the top level.
module pmet_port_checks
   import pmet_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input pmet_rsp_type rsp_data
);

   // A result that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // After a transaction is taken the block is busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   // An injection report is always suspicious, of injection kind, with no warning hint.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.injection_detected |->
         rsp_data.suspicious && (rsp_data.score_kind == SCORE_INJECTION)
         && !rsp_data.log_warning)
      else $error("inconsistent injection result");

   // A quiet result carries no kind, report or warning.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.suspicious |->
         (rsp_data.score_kind == SCORE_NONE) && !rsp_data.injection_detected
         && !rsp_data.log_warning)
      else $error("non-suspicious result carries flags");

   // Reset leaves no result on the output.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind process_memory_event_tracker pmet_port_checks u_pmet_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
